### hdl/lpht_pkg.sv
// Shared types and constants for the linear probe hash table.
// Holds request, status and entry encodings plus controller/datapath structs.
// No dependencies.
package lpht_pkg;

   // Fixed field widths of the request and result items
   localparam int KEY_W   = 4;
   localparam int DAY_W   = 5;
   localparam int YEAR_W  = 12;
   localparam int NAME_W  = 64;
   localparam int AGE_W   = 8;
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;

   // Configuration register reset values
   localparam logic [YEAR_W-1:0] YEAR_RESET  = 12'd2017;
   localparam logic [AGE_W-1:0]  ADULT_RESET = 8'd18;

   // Configuration register indexes, decoded from the word address
   localparam logic REG_YEAR  = 1'b0;
   localparam logic REG_ADULT = 1'b1;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_LIST   = 2'd2,
      REQ_COUNT  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_FULL     = 3'd1,
      ST_REMOVED  = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_LISTED   = 3'd4,
      ST_NONE     = 3'd5,
      ST_COUNT    = 3'd6
   } status_type;

   // One stored table entry
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [DAY_W-1:0]  day;
      logic [YEAR_W-1:0] year;
      logic [NAME_W-1:0] name;
   } entry_type;

   // Captured request
   typedef struct packed {
      req_kind_type kind;
      entry_type    entry;
   } request_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       issue;
      logic       write_entry;
      logic       mark_gone;
      logic       take_pend;
      logic       count_inc;
      logic       emit;
      status_type status;
      logic       last;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      req_kind_type kind;
      logic         chk_vld;
      logic         hit;
      logic         at_free;
      logic         all_checked;
      logic         pend_vld;
   } stat_type;

endpackage

### hdl/linear_probe_hash_table.sv
// Top level of the linear probe hash table: configuration registers, APB port,
// controller and datapath. Depends on lpht_pkg, lpht_ctrl, lpht_dp.
//
//   channel   ports                     handshake
//   request   req_*                     start high and busy low
//   result    rsp_*                     rsp_strobe, one cycle, no backpressure
//   config    psel penable pwrite ...   APB read and write, pready tied high
//
// A settled request shows its result once the final slot read passes the check
// stage and the result registers. A walk of every slot (full, list, count, long
// remove) reads the entry RAM one slot per cycle.
// A listed item is held until the next match, the final one until the scan ends.
// Reset marks every slot free at once and loads the register reset values.
// Results cannot be stalled; busy drops as the final item is registered.
module linear_probe_hash_table #(
   parameter int TABLE_SIZE = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_type,
   input  logic [lpht_pkg::KEY_W-1:0]        req_month,
   input  logic [lpht_pkg::DAY_W-1:0]        req_birth_day,
   input  logic [lpht_pkg::YEAR_W-1:0]       req_birth_year,
   input  logic [lpht_pkg::NAME_W-1:0]       req_name_tag,
   output logic                              rsp_strobe,
   output logic [2:0]                        rsp_status,
   output logic [lpht_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [lpht_pkg::NAME_W-1:0]       rsp_entry_name,
   output logic [lpht_pkg::COUNT_W-1:0]      rsp_adult_count,
   output logic                              rsp_last,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [2:0]                        paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   localparam int YEAR_W = lpht_pkg::YEAR_W;
   localparam int AGE_W  = lpht_pkg::AGE_W;

   logic [YEAR_W-1:0] year_ff;
   logic [YEAR_W-1:0] year_in;
   logic [AGE_W-1:0]  adult_ff;
   logic [AGE_W-1:0]  adult_in;
   logic              csr_wr;

   lpht_pkg::cmd_type  cmd;
   lpht_pkg::stat_type stat;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   // Decode register writes by word address
   always_comb begin
      year_in  = year_ff;
      adult_in = adult_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            lpht_pkg::REG_YEAR:  year_in  = pwdata[YEAR_W-1:0];
            lpht_pkg::REG_ADULT: adult_in = pwdata[AGE_W-1:0];
            default:             year_in  = year_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff  <= lpht_pkg::YEAR_RESET;
         adult_ff <= lpht_pkg::ADULT_RESET;
      end else begin
         year_ff  <= year_in;
         adult_ff <= adult_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (paddr[2])
         lpht_pkg::REG_YEAR:  prdata = {{(32-YEAR_W){1'b0}}, year_ff};
         lpht_pkg::REG_ADULT: prdata = {{(32-AGE_W){1'b0}}, adult_ff};
         default:             prdata = '0;
      endcase
   end

   lpht_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   lpht_dp #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_kind        (req_type),
      .req_month       (req_month),
      .req_day         (req_birth_day),
      .req_year        (req_birth_year),
      .req_tag         (req_name_tag),
      .cur_year        (year_ff),
      .adult_age       (adult_ff),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_entry_name  (rsp_entry_name),
      .rsp_adult_count (rsp_adult_count),
      .rsp_last        (rsp_last)
   );

endmodule

### hdl/lpht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the table entry store; no dependencies.
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/lpht_ctrl.sv
// Controller state machine for the linear probe hash table.
// Depends on lpht_pkg for the command and status structs.
module lpht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lpht_pkg::stat_type stat,
   output lpht_pkg::cmd_type  cmd
);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Decide commands from the check stage of the probe pipeline
   always_comb begin
      cmd        = '0;
      cmd.status = lpht_pkg::ST_INSERTED;
      cmd.last   = 1'b1;
      state_in   = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
            unique case (stat.kind)
               lpht_pkg::REQ_INSERT: begin
                  if (stat.chk_vld && stat.hit) begin
                     cmd.write_entry = 1'b1;
                     cmd.emit        = 1'b1;
                     cmd.status      = lpht_pkg::ST_INSERTED;
                     state_in        = S_IDLE;
                  end else if (stat.all_checked) begin
                     cmd.emit   = 1'b1;
                     cmd.status = lpht_pkg::ST_FULL;
                     state_in   = S_IDLE;
                  end
               end
               lpht_pkg::REQ_REMOVE: begin
                  if (stat.chk_vld && stat.at_free) begin
                     cmd.emit   = 1'b1;
                     cmd.status = lpht_pkg::ST_NOTFOUND;
                     state_in   = S_IDLE;
                  end else if (stat.chk_vld && stat.hit) begin
                     cmd.mark_gone = 1'b1;
                     cmd.emit      = 1'b1;
                     cmd.status    = lpht_pkg::ST_REMOVED;
                     state_in      = S_IDLE;
                  end else if (stat.all_checked) begin
                     cmd.emit   = 1'b1;
                     cmd.status = lpht_pkg::ST_NOTFOUND;
                     state_in   = S_IDLE;
                  end
               end
               lpht_pkg::REQ_LIST: begin
                  // Hold one match back so the final item can carry last
                  if (stat.chk_vld && stat.hit) begin
                     cmd.take_pend = 1'b1;
                     cmd.emit      = stat.pend_vld;
                     cmd.status    = lpht_pkg::ST_LISTED;
                     cmd.last      = 1'b0;
                  end else if (stat.all_checked) begin
                     cmd.emit   = 1'b1;
                     cmd.status = stat.pend_vld ? lpht_pkg::ST_LISTED : lpht_pkg::ST_NONE;
                     state_in   = S_IDLE;
                  end
               end
               lpht_pkg::REQ_COUNT: begin
                  cmd.count_inc = stat.chk_vld && stat.hit;
                  if (stat.all_checked) begin
                     cmd.emit   = 1'b1;
                     cmd.status = lpht_pkg::ST_COUNT;
                     state_in   = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff == S_SCAN);

endmodule

### hdl/lpht_dp.sv
// Datapath of the linear probe hash table: request capture, probe pipeline,
// slot marks, entry RAM and result registers. Depends on lpht_pkg, lpht_ram.
module lpht_dp #(
   parameter int TABLE_SIZE = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        req_kind,
   input  logic [lpht_pkg::KEY_W-1:0]        req_month,
   input  logic [lpht_pkg::DAY_W-1:0]        req_day,
   input  logic [lpht_pkg::YEAR_W-1:0]       req_year,
   input  logic [lpht_pkg::NAME_W-1:0]       req_tag,
   input  logic [lpht_pkg::YEAR_W-1:0]       cur_year,
   input  logic [lpht_pkg::AGE_W-1:0]        adult_age,
   input  lpht_pkg::cmd_type                 cmd,
   output lpht_pkg::stat_type                stat,
   output logic                              rsp_strobe,
   output logic [2:0]                        rsp_status,
   output logic [lpht_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [lpht_pkg::NAME_W-1:0]       rsp_entry_name,
   output logic [lpht_pkg::COUNT_W-1:0]      rsp_adult_count,
   output logic                              rsp_last
);

   localparam int IW      = $clog2(TABLE_SIZE);
   localparam int CW      = $clog2(TABLE_SIZE + 1);
   localparam int SLOT_W  = lpht_pkg::SLOT_W;
   localparam int COUNT_W = lpht_pkg::COUNT_W;
   localparam int YEAR_W  = lpht_pkg::YEAR_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);
   localparam logic [CW-1:0] PROBES   = CW'(TABLE_SIZE);

   lpht_pkg::request_type req_ff;
   lpht_pkg::request_type req_in;
   lpht_pkg::entry_type   rd_entry;

   logic [IW-1:0]         addr_ff;
   logic [IW-1:0]         addr_in;
   logic [CW-1:0]         probes_ff;
   logic [IW-1:0]         chk_idx_ff;
   logic                  chk_vld_ff;
   logic [TABLE_SIZE-1:0] used_ff;
   logic [TABLE_SIZE-1:0] gone_ff;
   logic                  pend_vld_ff;
   logic [IW-1:0]         pend_slot_ff;
   logic [lpht_pkg::NAME_W-1:0] pend_name_ff;
   logic [COUNT_W-1:0]    acc_ff;

   logic                  rsp_strobe_ff;
   lpht_pkg::status_type  rsp_status_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [SLOT_W-1:0]     rsp_slot_in;
   logic [lpht_pkg::NAME_W-1:0] rsp_name_ff;
   logic [lpht_pkg::NAME_W-1:0] rsp_name_in;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic [COUNT_W-1:0]    rsp_count_in;
   logic                  rsp_last_ff;

   logic                  chk_used;
   logic                  chk_gone;
   logic                  key_match;
   logic                  name_match;
   logic [YEAR_W:0]       age_diff;
   logic                  is_adult;
   logic                  hit;

   // Capture the request fields
   always_comb begin
      req_in.kind       = lpht_pkg::req_kind_type'(req_kind);
      req_in.entry.key  = req_month;
      req_in.entry.day  = req_day;
      req_in.entry.year = req_year;
      req_in.entry.name = req_tag;
   end

   // Probe address: start at home slot for insert/remove, slot 0 for scans
   always_comb begin
      if (cmd.load) begin
         if (req_in.kind == lpht_pkg::REQ_INSERT || req_in.kind == lpht_pkg::REQ_REMOVE) begin
            addr_in = IW'(req_month);
         end else begin
            addr_in = '0;
         end
      end else if (addr_ff == LAST_IDX) begin
         addr_in = '0;
      end else begin
         addr_in = addr_ff + 1'b1;
      end
   end

   // Entry store, read one slot per cycle while probing
   lpht_ram #(
      .WIDTH ($bits(lpht_pkg::entry_type)),
      .DEPTH (TABLE_SIZE)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.write_entry),
      .wr_addr (chk_idx_ff),
      .wr_data (req_ff.entry),
      .rd_en   (cmd.issue),
      .rd_addr (addr_ff),
      .rd_data (rd_entry)
   );

   // Compare the checked slot against the request
   always_comb begin
      chk_used   = used_ff[chk_idx_ff];
      chk_gone   = gone_ff[chk_idx_ff];
      key_match  = (rd_entry.key == req_ff.entry.key);
      name_match = (rd_entry.name == req_ff.entry.name);
      age_diff   = {1'b0, cur_year} - {1'b0, rd_entry.year};
      is_adult   = !age_diff[YEAR_W] &&
                   (age_diff[YEAR_W-1:0] >= YEAR_W'(adult_age));
      case (req_ff.kind)
         lpht_pkg::REQ_INSERT: hit = !chk_used;
         lpht_pkg::REQ_REMOVE: hit = chk_used && key_match && name_match;
         lpht_pkg::REQ_LIST:   hit = chk_used && key_match;
         default:              hit = chk_used && is_adult;
      endcase
   end

   always_comb begin
      stat.kind        = req_ff.kind;
      stat.chk_vld     = chk_vld_ff;
      stat.hit         = hit;
      stat.at_free     = !chk_used && !chk_gone;
      stat.all_checked = (probes_ff == PROBES) && !chk_vld_ff;
      stat.pend_vld    = pend_vld_ff;
   end

   // Select result payload by status
   always_comb begin
      rsp_slot_in  = '0;
      rsp_name_in  = '0;
      rsp_count_in = '0;
      case (cmd.status)
         lpht_pkg::ST_INSERTED, lpht_pkg::ST_REMOVED: begin
            rsp_slot_in = SLOT_W'(chk_idx_ff);
         end
         lpht_pkg::ST_LISTED: begin
            rsp_slot_in = SLOT_W'(pend_slot_ff);
            rsp_name_in = pend_name_ff;
         end
         lpht_pkg::ST_COUNT: begin
            rsp_count_in = acc_ff;
         end
         default: begin
            rsp_slot_in = '0;
         end
      endcase
   end

   // Control state: marks, pipeline valid, probe count, pending flag, result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         gone_ff       <= '0;
         chk_vld_ff    <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         probes_ff     <= '0;
      end else begin
         chk_vld_ff    <= cmd.issue && (probes_ff != PROBES);
         rsp_strobe_ff <= cmd.emit;
         if (cmd.write_entry) begin
            used_ff[chk_idx_ff] <= 1'b1;
            gone_ff[chk_idx_ff] <= 1'b0;
         end
         if (cmd.mark_gone) begin
            used_ff[chk_idx_ff] <= 1'b0;
            gone_ff[chk_idx_ff] <= 1'b1;
         end
         if (cmd.load) begin
            pend_vld_ff <= 1'b0;
            probes_ff   <= '0;
         end else begin
            if (cmd.take_pend) begin
               pend_vld_ff <= 1'b1;
            end
            if (cmd.issue && (probes_ff != PROBES)) begin
               probes_ff <= probes_ff + 1'b1;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      chk_idx_ff <= addr_ff;
      if (cmd.load) begin
         req_ff  <= req_in;
         addr_ff <= addr_in;
         acc_ff  <= '0;
      end else begin
         if (cmd.issue && (probes_ff != PROBES)) begin
            addr_ff <= addr_in;
         end
         if (cmd.count_inc) begin
            acc_ff <= acc_ff + 1'b1;
         end
      end
      if (cmd.take_pend) begin
         pend_slot_ff <= chk_idx_ff;
         pend_name_ff <= rd_entry.name;
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.status;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_name_ff   <= rsp_name_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= cmd.last;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_entry_name  = rsp_name_ff;
   assign rsp_adult_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

### bench/lpht_checker.sv
// Result checker for the linear probe hash table: snoops the request, result and APB
// channels, keeps its own copy of the table and registers, and compares every result item.
// Depends on lpht_pkg.
`timescale 1ns / 100ps

module lpht_checker
   import lpht_pkg::*;
#(
   parameter int TABLE_SIZE = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_type,
   input  logic [KEY_W-1:0]   req_month,
   input  logic [DAY_W-1:0]   req_birth_day,
   input  logic [YEAR_W-1:0]  req_birth_year,
   input  logic [NAME_W-1:0]  req_name_tag,
   input  logic               rsp_strobe,
   input  logic [2:0]         rsp_status,
   input  logic [SLOT_W-1:0]  rsp_slot,
   input  logic [NAME_W-1:0]  rsp_entry_name,
   input  logic [COUNT_W-1:0] rsp_adult_count,
   input  logic               rsp_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   input  logic [31:0]        prdata,
   input  logic               pready,
   output int                 fail_count,
   output int                 pending
);

   typedef enum logic [1:0] {
      SLOT_FREE = 2'd0,
      SLOT_USED = 2'd1,
      SLOT_GONE = 2'd2
   } slot_state_type;

   typedef struct {
      status_type         status;
      logic [SLOT_W-1:0]  slot;
      logic [NAME_W-1:0]  name;
      logic [COUNT_W-1:0] count;
      logic               last;
   } answer_type;

   // Shadow table and registers
   slot_state_type    slot_state [TABLE_SIZE];
   logic [KEY_W-1:0]  slot_key   [TABLE_SIZE];
   logic [DAY_W-1:0]  slot_day   [TABLE_SIZE];
   logic [YEAR_W-1:0] slot_year  [TABLE_SIZE];
   logic [NAME_W-1:0] slot_name  [TABLE_SIZE];
   logic [YEAR_W-1:0] cfg_year;
   logic [AGE_W-1:0]  cfg_adult;

   // Result items still owed by the block, oldest first
   answer_type table_answers [$];

   function automatic answer_type make_answer(status_type st, int slot,
                                              logic [NAME_W-1:0] nm, int cnt, logic lst);
      answer_type a;
      a.status = st;
      a.slot   = SLOT_W'(slot);
      a.name   = nm;
      a.count  = COUNT_W'(cnt);
      a.last   = lst;
      return a;
   endfunction

   // Update the shadow table for one accepted item and queue its result items
   task automatic apply_request(input req_kind_type kind, input logic [KEY_W-1:0] month,
                                input logic [DAY_W-1:0] day, input logic [YEAR_W-1:0] year,
                                input logic [NAME_W-1:0] tag);
      int home;
      int s;
      int n;
      int cy;
      int by;
      bit done;
      bit hit;
      answer_type a;
      home = int'(month) % TABLE_SIZE;
      done = 1'b0;
      hit  = 1'b0;
      n    = 0;
      case (kind)
         REQ_INSERT: begin
            // take the first free or removed slot from the home slot
            for (int i = 0; i < TABLE_SIZE; i++) begin
               s = (home + i) % TABLE_SIZE;
               if (!done && slot_state[s] != SLOT_USED) begin
                  slot_state[s] = SLOT_USED;
                  slot_key[s]   = month;
                  slot_day[s]   = day;
                  slot_year[s]  = year;
                  slot_name[s]  = tag;
                  table_answers.push_back(make_answer(ST_INSERTED, s, '0, 0, 1'b1));
                  done = 1'b1;
               end
            end
            if (!done) table_answers.push_back(make_answer(ST_FULL, 0, '0, 0, 1'b1));
         end
         REQ_REMOVE: begin
            // probe until a free slot; skip removed and non-matching entries
            for (int i = 0; i < TABLE_SIZE; i++) begin
               s = (home + i) % TABLE_SIZE;
               if (!done) begin
                  if (slot_state[s] == SLOT_FREE) begin
                     done = 1'b1;
                  end else if (slot_state[s] == SLOT_USED && slot_key[s] == month &&
                               slot_name[s] == tag) begin
                     slot_state[s] = SLOT_GONE;
                     table_answers.push_back(make_answer(ST_REMOVED, s, '0, 0, 1'b1));
                     done = 1'b1;
                     hit  = 1'b1;
                  end
               end
            end
            if (!hit) table_answers.push_back(make_answer(ST_NOTFOUND, 0, '0, 0, 1'b1));
         end
         REQ_LIST: begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
               if (slot_state[i] == SLOT_USED && slot_key[i] == month) begin
                  table_answers.push_back(make_answer(ST_LISTED, i, slot_name[i], 0, 1'b0));
                  n++;
               end
            end
            if (n == 0) begin
               table_answers.push_back(make_answer(ST_NONE, 0, '0, 0, 1'b1));
            end else begin
               // flag the final listed entry
               a = table_answers.pop_back();
               a.last = 1'b1;
               table_answers.push_back(a);
            end
         end
         default: begin
            // count entries old enough; a birth year past the current year never counts
            cy = int'(cfg_year);
            for (int i = 0; i < TABLE_SIZE; i++) begin
               by = int'(slot_year[i]);
               if (slot_state[i] == SLOT_USED && cy >= by && (cy - by) >= int'(cfg_adult))
                  n++;
            end
            table_answers.push_back(make_answer(ST_COUNT, 0, '0, n, 1'b1));
         end
      endcase
   endtask

   // Compare one result item against the oldest owed item
   task automatic check_answer();
      answer_type a;
      if (table_answers.size() == 0) begin
         $error("unexpected result item: status %0d slot %0d", rsp_status, rsp_slot);
         fail_count++;
      end else begin
         a = table_answers.pop_front();
         if (rsp_status !== a.status) begin
            $error("status: expected %0d, got %0d", a.status, rsp_status);
            fail_count++;
         end
         if (rsp_slot !== a.slot) begin
            $error("slot: expected %0d, got %0d", a.slot, rsp_slot);
            fail_count++;
         end
         if (rsp_entry_name !== a.name) begin
            $error("entry_name: expected %h, got %h", a.name, rsp_entry_name);
            fail_count++;
         end
         if (rsp_adult_count !== a.count) begin
            $error("adult_count: expected %0d, got %0d", a.count, rsp_adult_count);
            fail_count++;
         end
         if (rsp_last !== a.last) begin
            $error("last: expected %0d, got %0d", a.last, rsp_last);
            fail_count++;
         end
      end
   endtask

   // Watch all three channels at each rising edge
   always @(posedge clock) begin
      logic [31:0] reg_value;
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE; i++) begin
            slot_state[i] = SLOT_FREE;
            slot_key[i]   = '0;
            slot_day[i]   = '0;
            slot_year[i]  = '0;
            slot_name[i]  = '0;
         end
         cfg_year  = YEAR_RESET;
         cfg_adult = ADULT_RESET;
         table_answers.delete();
      end else begin
         if (rsp_strobe) check_answer();
         reg_value = (paddr[2] == REG_YEAR) ? 32'(cfg_year) : 32'(cfg_adult);
         if (psel && penable && pready && !pwrite && prdata !== reg_value) begin
            $error("prdata at %0d: expected %0d, got %0d", paddr, reg_value, prdata);
            fail_count++;
         end
         if (psel && penable && pready && pwrite) begin
            if (paddr[2] == REG_YEAR) cfg_year = pwdata[YEAR_W-1:0];
            else cfg_adult = pwdata[AGE_W-1:0];
         end
         if (start && !busy)
            apply_request(req_kind_type'(req_type), req_month, req_birth_day,
                          req_birth_year, req_name_tag);
      end
      pending = table_answers.size();
   end

endmodule

### bench/linear_probe_hash_table_test.sv
// Top of the linear probe hash table bench: clock, reset, request and APB stimulus,
// watchdog and verdict. Depends on lpht_pkg, linear_probe_hash_table and lpht_checker.
`timescale 1ns / 100ps

module linear_probe_hash_table_test;
   import lpht_pkg::*;

   localparam int TABLE_SIZE  = 64;
   localparam int QUIET_LIMIT = 2000;

   typedef struct {
      logic [KEY_W-1:0]  month;
      logic [NAME_W-1:0] name;
   } stored_pair_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_type;
   logic [KEY_W-1:0]    req_month;
   logic [DAY_W-1:0]    req_birth_day;
   logic [YEAR_W-1:0]   req_birth_year;
   logic [NAME_W-1:0]   req_name_tag;
   logic                rsp_strobe;
   logic [2:0]          rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [NAME_W-1:0]   rsp_entry_name;
   logic [COUNT_W-1:0]  rsp_adult_count;
   logic                rsp_last;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [2:0]          paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;

   int                  fail_count;
   int                  pending;
   int                  quiet_cycles = 0;
   int                  burst_left;
   logic [YEAR_W-1:0]   cur_year;
   logic [AGE_W-1:0]    cur_adult;
   stored_pair_type     live_pairs [$];
   logic [NAME_W-1:0]   name_pool [4] = '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                                          64'h5555_AAAA_5555_AAAA, 64'h0000_0000_0000_0001};

   always #2 clock = ~clock;

   linear_probe_hash_table #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_month(req_month), .req_birth_day(req_birth_day),
      .req_birth_year(req_birth_year), .req_name_tag(req_name_tag),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_slot(rsp_slot),
      .rsp_entry_name(rsp_entry_name), .rsp_adult_count(rsp_adult_count),
      .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   lpht_checker #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_month(req_month), .req_birth_day(req_birth_day),
      .req_birth_year(req_birth_year), .req_name_tag(req_name_tag),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_slot(rsp_slot),
      .rsp_entry_name(rsp_entry_name), .rsp_adult_count(rsp_adult_count),
      .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .fail_count(fail_count), .pending(pending)
   );

   // End the run when no channel has moved for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Insert a gap between bursts of items; a zero gap keeps start high
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Present one item and hold it until the block takes it
   task automatic send_request(input req_kind_type kind, input logic [KEY_W-1:0] month,
                               input logic [DAY_W-1:0] day, input logic [YEAR_W-1:0] year,
                               input logic [NAME_W-1:0] tag);
      req_type       <= kind;
      req_month      <= month;
      req_birth_day  <= day;
      req_birth_year <= year;
      req_name_tag   <= tag;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pace();
   endtask

   function automatic logic [KEY_W-1:0] pick_month();
      // months 13..15 and 0 are ordinary keys too
      if ($urandom_range(0, 6) == 0) return KEY_W'($urandom_range(13, 16));
      return KEY_W'($urandom_range(1, 12));
   endfunction

   function automatic logic [YEAR_W-1:0] pick_year();
      if ($urandom_range(0, 3) == 0) return YEAR_W'($urandom_range(0, 4095));
      return cur_year - YEAR_W'($urandom_range(0, 60));
   endfunction

   function automatic logic [NAME_W-1:0] pick_name();
      if ($urandom_range(0, 3) == 0) return name_pool[$urandom_range(0, 3)];
      return {$urandom, $urandom};
   endfunction

   task automatic insert_item(input logic [KEY_W-1:0] month);
      stored_pair_type pair;
      pair.month = month;
      pair.name  = pick_name();
      live_pairs.push_back(pair);
      send_request(REQ_INSERT, month, DAY_W'($urandom_range(0, 31)), pick_year(), pair.name);
   endtask

   // Mixed traffic: mostly inserts and removes of stored entries, plus lists, counts and noise
   task automatic random_item();
      int pick;
      int idx;
      stored_pair_type pair;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         insert_item(pick_month());
      end else if (pick < 70) begin
         if (live_pairs.size() > 0 && $urandom_range(0, 3) != 0) begin
            idx  = $urandom_range(0, live_pairs.size() - 1);
            pair = live_pairs[idx];
            live_pairs.delete(idx);
         end else begin
            pair.month = pick_month();
            pair.name  = pick_name();
         end
         send_request(REQ_REMOVE, pair.month, DAY_W'($urandom_range(0, 31)),
                      YEAR_W'($urandom_range(0, 4095)), pair.name);
      end else if (pick < 85) begin
         send_request(REQ_LIST, pick_month(), DAY_W'($urandom_range(0, 31)),
                      YEAR_W'($urandom_range(0, 4095)), {$urandom, $urandom});
      end else begin
         send_request(REQ_COUNT, KEY_W'($urandom_range(0, 15)), DAY_W'($urandom_range(0, 31)),
                      YEAR_W'($urandom_range(0, 4095)), {$urandom, $urandom});
      end
   endtask

   // Drop start and wait until the block owes nothing and has gone idle
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (TABLE_SIZE + 4) @(posedge clock);
   endtask

   // APB write of one register, then a read back
   task automatic write_reg(input logic idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_config(input logic [YEAR_W-1:0] year, input logic [AGE_W-1:0] adult);
      settle();
      write_reg(REG_YEAR, {20'($urandom), year});
      write_reg(REG_ADULT, {24'($urandom), adult});
      cur_year  = year;
      cur_adult = adult;
   endtask

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_type       <= '0;
      req_month      <= '0;
      req_birth_day  <= '0;
      req_birth_year <= '0;
      req_name_tag   <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      burst_left = 0;
      cur_year   = YEAR_RESET;
      cur_adult  = ADULT_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, chains through neighbors, removed-slot reuse, edge ages
      send_request(REQ_COUNT, 4'd0, 5'd0, 12'd0, 64'd0);
      send_request(REQ_LIST, 4'd5, 5'd31, 12'd4095, '1);
      send_request(REQ_REMOVE, 4'd5, 5'd0, 12'd0, 64'd0);
      send_request(REQ_INSERT, 4'd0, 5'd31, 12'd0, '1);
      send_request(REQ_INSERT, 4'd15, 5'd0, 12'd4095, 64'd0);
      send_request(REQ_INSERT, 4'd12, 5'd1, 12'd1999, name_pool[0]);
      send_request(REQ_INSERT, 4'd12, 5'd2, 12'd2000, name_pool[0]);
      send_request(REQ_INSERT, 4'd12, 5'd3, 12'd1980, name_pool[1]);
      send_request(REQ_INSERT, 4'd13, 5'd4, 12'd2017, name_pool[2]);
      send_request(REQ_LIST, 4'd12, 5'd0, 12'd0, 64'd0);
      send_request(REQ_REMOVE, 4'd12, 5'd0, 12'd0, name_pool[2]);
      send_request(REQ_REMOVE, 4'd12, 5'd0, 12'd0, name_pool[0]);
      send_request(REQ_REMOVE, 4'd12, 5'd0, 12'd0, name_pool[1]);
      send_request(REQ_INSERT, 4'd12, 5'd5, 12'd1999, name_pool[3]);
      send_request(REQ_COUNT, 4'd15, 5'd31, 12'd4095, '1);
      send_request(REQ_LIST, 4'd0, 5'd0, 12'd0, 64'd0);
      send_request(REQ_LIST, 4'd14, 5'd0, 12'd0, 64'd0);
      send_request(REQ_INSERT, 4'd1, 5'd31, 12'd4095, 64'h8000_0000_0000_0001);
      send_request(REQ_REMOVE, 4'd0, 5'd31, 12'd4095, '1);
      send_request(REQ_LIST, 4'd12, 5'd0, 12'd0, 64'd0);
      send_request(REQ_COUNT, 4'd0, 5'd0, 12'd0, 64'd0);

      // Latest possible reference year, everyone adult
      set_config(12'd4095, 8'd0);
      repeat (20) random_item();

      // Fill the table with a few months, then probe a full table
      set_config(YEAR_W'($urandom_range(1950, 2100)), AGE_W'($urandom_range(0, 60)));
      repeat (70) insert_item(KEY_W'($urandom_range(1, 3)));
      repeat (3) send_request(REQ_REMOVE, 4'd15, 5'd0, 12'd0, {$urandom, $urandom});
      repeat (12) random_item();

      // Year zero and the highest adult age: ages go negative, nobody counts
      set_config(12'd0, 8'd255);
      repeat (15) random_item();

      set_config(YEAR_W'($urandom_range(1950, 2100)), AGE_W'($urandom_range(0, 60)));
      repeat (10) random_item();

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
